// ===== hw/rtl/dmxfm_pkg.sv =====
`default_nettype none
package dmxfm_pkg;

  localparam int SLOT_COUNT_DEF = 513;

  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;   // byte count and frame length
  localparam int RATE_W   = 12;
  localparam int PCT_W    = 7;
  localparam int ERR_W    = 2;
  localparam int FRM_W    = 16;   // window frame counters
  localparam int WIN_W    = 4;
  localparam int NUM_W    = 23;   // errored frames * 100

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [CNT_W-1:0]  BYTE_CNT_MAX = 11'd2047;
  localparam logic [RATE_W-1:0] RATE_MAX     = 12'd4095;
  localparam logic [FRM_W-1:0]  FRM_MAX      = 16'd65535;
  localparam logic [PCT_W-1:0]  PCT_MAX      = 7'd100;
  localparam logic [WIN_W-1:0]  WIN_RESET    = 4'd3;
  localparam logic [BYTE_W-1:0] START_RDM    = 8'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_BREAK = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_RDM    = 2'd2,
    ERR_SYNTAX = 2'd3
  } err_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch input transaction
    logic look;       // store read, divider launch point
    logic div_start;
    logic exec;       // apply the item's state update
    logic out_load;   // load the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic need_div;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dmxfm_div.sv =====
`default_nettype none
module dmxfm_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [dmxfm_pkg::NUM_W-1:0] dividend,
  input  wire logic [dmxfm_pkg::FRM_W-1:0] divisor,
  output logic                             done,
  output logic [dmxfm_pkg::NUM_W-1:0]      quotient
);
  import dmxfm_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [FRM_W-1:0]  rem_r, rem_nxt;
  logic [FRM_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [FRM_W:0]    trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(NUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = FRM_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[FRM_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    if (start) dvs_r <= divisor;
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dmxfm_dp.sv =====
`default_nettype none
module dmxfm_dp #(
  parameter int SLOT_COUNT = dmxfm_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dmxfm_pkg::dp_cmd_t               ctl,
  output dmxfm_pkg::dp_sts_t                    sts,
  input  wire logic [dmxfm_pkg::IN_DATA_W-1:0]  in_data,
  input  wire logic [dmxfm_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic                             cfg_we,
  input  wire logic [dmxfm_pkg::WIN_W-1:0]      cfg_win,
  output logic [dmxfm_pkg::OUT_DATA_W-1:0]      out_data
);
  import dmxfm_pkg::*;

  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOT_COUNT);

  // channel store; entries at or above the fill mark read as zero
  logic [BYTE_W-1:0] store_mem [SLOT_COUNT];
  logic [BYTE_W-1:0] rd_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  logic [CNT_W-1:0]  fill_r, fill_nxt;
  cmd_t              cmd_r;
  logic [BYTE_W-1:0] byte_r;
  logic [IDX_W-1:0]  idx_r;

  logic [CNT_W-1:0]  bc_r, bc_nxt;
  logic [RATE_W-1:0] frames_r, frames_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  err_t              pend_r, pend_nxt;
  err_t              win_err_r, win_err_nxt;
  err_t              rep_r, rep_nxt;
  logic [FRM_W-1:0]  errd_r, errd_nxt;
  logic [FRM_W-1:0]  chkd_r, chkd_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic [WIN_W-1:0]  phase_r, phase_nxt;
  logic              chg_r, chg_nxt;
  logic [WIN_W-1:0]  win_cfg_r;
  logic [BYTE_W-1:0] rdval_r, rdval_nxt;
  logic [OUT_DATA_W-1:0] out_r;

  logic [BYTE_W-1:0] stored;
  logic [NUM_W-1:0]  quo;
  logic              div_done;
  logic [NUM_W-1:0]  numer;
  logic [WIN_W:0]    phase_inc;

  assign numer = NUM_W'(errd_r) * NUM_W'(PCT_MAX);

  dmxfm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (numer),
    .divisor  (chkd_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign rd_addr = (cmd_r == CMD_READ) ? idx_r[ADDR_W-1:0] : bc_r[ADDR_W-1:0];
  assign wr_en   = ctl.exec && (cmd_r == CMD_BYTE) && (bc_r < SLOTS);

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[bc_r[ADDR_W-1:0]] <= byte_r;
    if (ctl.look) rd_r <= store_mem[rd_addr];
  end

  assign stored    = (bc_r < fill_r) ? rd_r : '0;
  assign phase_inc = {1'b0, phase_r} + 1'b1;

  always_comb begin
    fill_nxt    = fill_r;
    bc_nxt      = bc_r;
    frames_nxt  = frames_r;
    rate_nxt    = rate_r;
    len_nxt     = len_r;
    pend_nxt    = pend_r;
    win_err_nxt = win_err_r;
    rep_nxt     = rep_r;
    errd_nxt    = errd_r;
    chkd_nxt    = chkd_r;
    pct_nxt     = pct_r;
    phase_nxt   = phase_r;
    chg_nxt     = chg_r;
    rdval_nxt   = '0;
    if (ctl.exec) begin
      case (cmd_r)
        CMD_BYTE: begin
          if (bc_r < SLOTS) begin
            if (bc_r == '0) begin
              if (byte_r == START_RDM) pend_nxt = ERR_RDM;
              else if (byte_r != '0)   pend_nxt = ERR_SYNTAX;
            end
            if (stored != byte_r) chg_nxt = 1'b1;
            if (bc_r == fill_r) fill_nxt = fill_r + 1'b1;
          end
          if (bc_r > SLOTS) begin
            pend_nxt = ERR_LENGTH;
          end else if (bc_r != BYTE_CNT_MAX) begin
            bc_nxt = bc_r + 1'b1;
          end
        end
        CMD_BREAK: begin
          if (frames_r != RATE_MAX) frames_nxt = frames_r + 1'b1;
          len_nxt = (bc_r > CNT_W'(1)) ? bc_r - 1'b1 : '0;
          bc_nxt  = '0;
          if (pend_r != ERR_NONE) begin
            win_err_nxt = pend_r;
            if (errd_r != FRM_MAX) errd_nxt = errd_r + 1'b1;
            pend_nxt = ERR_NONE;
          end else begin
            chg_nxt = 1'b0;
          end
          if (chkd_r != FRM_MAX) chkd_nxt = chkd_r + 1'b1;
        end
        CMD_TICK: begin
          rate_nxt   = frames_r;
          frames_nxt = '0;
          if (phase_r == '0) begin
            if (chkd_r != '0) begin
              pct_nxt  = (quo > NUM_W'(PCT_MAX)) ? PCT_MAX : quo[PCT_W-1:0];
              pend_nxt = ERR_NONE;
            end
            rep_nxt     = win_err_r;
            win_err_nxt = ERR_NONE;
            errd_nxt    = '0;
            chkd_nxt    = '0;
          end
          // a zero window behaves like one: every tick wraps
          phase_nxt = (phase_inc >= {1'b0, win_cfg_r}) ? '0 : phase_inc[WIN_W-1:0];
        end
        CMD_READ: begin
          if ({1'b0, idx_r} < fill_r) rdval_nxt = rd_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd_t'(in_cmd);
      byte_r <= in_data[BYTE_W-1:0];
      idx_r  <= in_data[BYTE_W +: IDX_W];
    end
    if (ctl.exec) rdval_r <= rdval_nxt;
    if (ctl.out_load) begin
      out_r <= {7'b0, rdval_r, chg_r, rep_r, pct_r, len_r, rate_r};
    end
    if (!rst_n) begin
      fill_r    <= '0;
      bc_r      <= '0;
      frames_r  <= '0;
      rate_r    <= '0;
      len_r     <= '0;
      pend_r    <= ERR_NONE;
      win_err_r <= ERR_NONE;
      rep_r     <= ERR_NONE;
      errd_r    <= '0;
      chkd_r    <= '0;
      pct_r     <= '0;
      phase_r   <= '0;
      chg_r     <= 1'b0;
      win_cfg_r <= WIN_RESET;
    end else begin
      fill_r    <= fill_nxt;
      bc_r      <= bc_nxt;
      frames_r  <= frames_nxt;
      rate_r    <= rate_nxt;
      len_r     <= len_nxt;
      pend_r    <= pend_nxt;
      win_err_r <= win_err_nxt;
      rep_r     <= rep_nxt;
      errd_r    <= errd_nxt;
      chkd_r    <= chkd_nxt;
      pct_r     <= pct_nxt;
      phase_r   <= phase_nxt;
      chg_r     <= chg_nxt;
      if (cfg_we) win_cfg_r <= cfg_win;
    end
  end

  assign sts.cmd      = cmd_r;
  assign sts.need_div = (phase_r == '0) && (chkd_r != '0);
  assign sts.div_done = div_done;
  assign out_data     = out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dmxfm_ctrl.sv =====
`default_nettype none
module dmxfm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire dmxfm_pkg::dp_sts_t  sts,
  output dmxfm_pkg::dp_cmd_t       ctl
);
  import dmxfm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_EXEC,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl.look = 1'b1;
        if (sts.cmd == CMD_TICK && sts.need_div) begin
          ctl.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (ctl.out_load)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dmx512_frame_monitor.sv =====
// DMX512 frame monitor.
// Input channel (in_*): one transaction per event. in_tuser is the command
// (data byte, break, one-second tick, channel read); in_tdata carries the
// slot byte and the channel index to read.
// Output channel (out_*): exactly one transaction per input transaction, in
// order, carrying the latched statistics after that event and the read value.
// Config channel (cfg_*): always ready; writes the error window length in
// ticks. Write it only while no event is in flight.
// Timing: a result is registered through the controller states look, exec and
// result for every event except a tick that closes an error window holding
// frames; that one also runs the bit-serial percent divider (23 steps) before
// exec. One event is worked on at a time: the next input is taken only after
// the result of the last one has been loaded into the output register.
// Stall: the output register holds a result while out_tready is low; the next
// event is still accepted and worked, then waits for the register to free.
// Reset (rst_n low, synchronous): all statistics clear, the window returns to
// 3 ticks; the channel store reads as zero at and above its fill mark, so no
// clearing pass is needed and the block is ready right after reset.
`default_nettype none
module dmx512_frame_monitor #(
  parameter int SLOT_COUNT = dmxfm_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [7:0] data_byte, [17:8] channel_index, [23:18] zero
  input  wire logic [dmxfm_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  wire logic [dmxfm_pkg::CMD_W-1:0]         in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [11:0] frame_rate, [22:12] frame_slots, [29:23] error_percent,
  // [31:30] last_error, [32] change_pending, [40:33] read_value, [47:41] zero
  output logic [dmxfm_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  // error_window_ticks
  input  wire logic [dmxfm_pkg::WIN_W-1:0]         cfg_data
);
  import dmxfm_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  // window register takes a write on any cycle
  assign cfg_ready = 1'b1;

  dmxfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  dmxfm_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sts      (sts),
    .in_data  (in_tdata),
    .in_cmd   (in_tuser),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_win  (cfg_data),
    .out_data (out_tdata)
  );

endmodule
`default_nettype wire

// ===== dv/dmx512_frame_monitor_checker.sv =====
module dmx512_frame_monitor_checker
  import dmxfm_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [CMD_W-1:0]      in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [WIN_W-1:0]      cfg_data,
  output int                         fail_count,
  output int                         backlog,
  output int                         results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [RATE_W-1:0] rate;
    logic [CNT_W-1:0]  length;
    logic [PCT_W-1:0]  percent;
    err_t              last_err;
    logic              changed;
    logic [BYTE_W-1:0] rd;
  } status_t;

  status_t expected_status[$];

  // shadow of the monitor state
  logic [BYTE_W-1:0] slot_mem [SLOT_COUNT];
  int unsigned       byte_cnt, frames_sec, rate_q, len_q;
  int unsigned       win_errs, win_frames, pct_q, tick_ph;
  err_t              pend_err, win_err, rep_err;
  logic              chg;
  logic [WIN_W-1:0]  win_len;

  function automatic status_t advance_monitor(cmd_t c, logic [BYTE_W-1:0] b,
                                              logic [IDX_W-1:0] idx);
    status_t s;
    int unsigned ratio;
    s.rd = '0;
    case (c)
      CMD_BYTE: begin
        if (byte_cnt < SLOT_COUNT) begin
          if (byte_cnt == 0) begin
            if (b == START_RDM) pend_err = ERR_RDM;
            else if (b != 0) pend_err = ERR_SYNTAX;
          end
          if (slot_mem[byte_cnt] != b) chg = 1'b1;
          slot_mem[byte_cnt] = b;
        end else if (byte_cnt > SLOT_COUNT) begin
          pend_err = ERR_LENGTH;
        end
        // bytes past the slot count plus one are not counted
        if (byte_cnt <= SLOT_COUNT && byte_cnt < BYTE_CNT_MAX) byte_cnt++;
      end
      CMD_BREAK: begin
        if (frames_sec < RATE_MAX) frames_sec++;
        len_q = (byte_cnt > 1) ? byte_cnt - 1 : 0;
        if (len_q > 2046) len_q = 2046;
        byte_cnt = 0;
        if (pend_err != ERR_NONE) begin
          win_err = pend_err;
          if (win_errs < FRM_MAX) win_errs++;
          pend_err = ERR_NONE;
        end else begin
          chg = 1'b0;
        end
        if (win_frames < FRM_MAX) win_frames++;
      end
      CMD_TICK: begin
        rate_q     = frames_sec;
        frames_sec = 0;
        if (tick_ph == 0) begin
          if (win_frames > 0) begin
            ratio    = win_errs * 100 / win_frames;
            pct_q    = (ratio > PCT_MAX) ? PCT_MAX : ratio;
            pend_err = ERR_NONE;
          end
          rep_err    = win_err;
          win_err    = ERR_NONE;
          win_errs   = 0;
          win_frames = 0;
        end
        // a zero window length behaves as one; a shrunk window wraps now
        tick_ph = (tick_ph + 1 >= win_len) ? 0 : (tick_ph + 1) & 15;
      end
      default: begin
        if (idx < SLOT_COUNT) s.rd = slot_mem[idx];
      end
    endcase
    s.rate     = rate_q[RATE_W-1:0];
    s.length   = len_q[CNT_W-1:0];
    s.percent  = pct_q[PCT_W-1:0];
    s.last_err = rep_err;
    s.changed  = chg;
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count   = 0;
    backlog      = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin : watch
    status_t want;
    status_t got;
    if (!rst_n) begin
      foreach (slot_mem[i]) slot_mem[i] = '0;
      byte_cnt   = 0;
      frames_sec = 0;
      rate_q     = 0;
      len_q      = 0;
      win_errs   = 0;
      win_frames = 0;
      pct_q      = 0;
      tick_ph    = 0;
      pend_err   = ERR_NONE;
      win_err    = ERR_NONE;
      rep_err    = ERR_NONE;
      chg        = 1'b0;
      win_len    = WIN_RESET;
      expected_status.delete();
      backlog    = 0;
    end else begin
      if (cfg_valid && cfg_ready) win_len = cfg_data;
      if (in_tvalid && in_tready)
        expected_status.push_back(advance_monitor(cmd_t'(in_tuser),
                                                  in_tdata[BYTE_W-1:0],
                                                  in_tdata[BYTE_W +: IDX_W]));
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.rate     = out_tdata[11:0];
        got.length   = out_tdata[22:12];
        got.percent  = out_tdata[29:23];
        got.last_err = err_t'(out_tdata[31:30]);
        got.changed  = out_tdata[32];
        got.rd       = out_tdata[40:33];
        if (expected_status.size() == 0) begin
          $error("result transaction with no event outstanding");
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("frame_rate", want.rate, got.rate);
          check_field("frame_slots", want.length, got.length);
          check_field("error_percent", want.percent, got.percent);
          check_field("last_error", want.last_err, got.last_err);
          check_field("change_pending", want.changed, got.changed);
          check_field("read_value", want.rd, got.rd);
        end
      end
      backlog = expected_status.size();
    end
  end

endmodule

// ===== dv/dmx512_frame_monitor_tb.sv =====
module dmx512_frame_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmxfm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1620;
  localparam int unsigned BURST_BREAKS = 300;    // window counters run up without a tick
  localparam int unsigned LIMIT        = 1_000_000;
  localparam int unsigned SETTLE       = 40;     // longer than a window-closing tick

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // [7:0] data_byte, [17:8] channel_index, [23:18] zero
  logic [IN_DATA_W-1:0]  in_tdata;
  // [1:0] cmd
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // [11:0] frame_rate, [22:12] frame_slots, [29:23] error_percent,
  // [31:30] last_error, [32] change_pending, [40:33] read_value, [47:41] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  // error_window_ticks
  logic [WIN_W-1:0]      cfg_data;

  int          fails, backlog, results_seen;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned sent_by_cmd [4];
  bit          src_quiet = 1'b0;   // no gaps between input transactions
  bit          sink_quiet = 1'b0;  // out_tready held high
  logic [BYTE_W-1:0] scene [16];   // slot pattern reused across frames

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dmx512_frame_monitor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  dmx512_frame_monitor_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fails),
    .backlog      (backlog),
    .results_seen (results_seen)
  );

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("** dmx512_frame_monitor: FAILED **");
      $finish;
    end
  end

  // Result sink: after every result transaction draw a random stall length.
  // out_tready is sampled before the edge's updates, then changed at the
  // falling edge only.
  initial begin : sink
    int unsigned sink_wait;
    sink_wait  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready)
        sink_wait = sink_quiet ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (sink_wait > 0) begin
        out_tready <= 1'b0;
        sink_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One input transaction. Called at a falling edge, returns at one.
  // in_tvalid stays high across back-to-back transactions.
  task automatic send_event(cmd_t c, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {{(IN_DATA_W-BYTE_W-IDX_W){1'b0}}, idx, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_by_cmd[c]++;
    items_sent++;
  endtask

  // Window length writes only happen with nothing in flight; every event
  // yields a result, so an empty backlog means the block is idle.
  task automatic write_window(logic [WIN_W-1:0] ticks);
    in_tvalid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A frame: start code, slots, break. Most frames are short; a few run up
  // to and past the full slot count to hit the exact fill and length errors.
  // Slot data mostly repeats a pattern so that both changed and unchanged
  // frames occur. Now and then the break is dropped and two frames merge.
  task automatic send_frame();
    int unsigned pick, slots;
    logic [BYTE_W-1:0] lead;
    pick = $urandom_range(0, 99);
    if (pick < 85) slots = $urandom_range(0, 24);
    else if (pick < 96) slots = $urandom_range(25, 120);
    else slots = $urandom_range(505, 530);
    pick = $urandom_range(0, 9);
    if (pick < 8) lead = 8'd0;
    else if (pick == 8) lead = START_RDM;
    else lead = 8'($urandom_range(2, 255));
    if ($urandom_range(0, 5) == 0) scene[$urandom_range(0, 15)] = 8'($urandom);
    send_event(CMD_BYTE, lead, 10'($urandom));
    for (int k = 1; k <= slots; k++) begin
      if ($urandom_range(0, 7) != 0) send_event(CMD_BYTE, scene[k % 16], 10'($urandom));
      else send_event(CMD_BYTE, 8'($urandom), 10'($urandom));
      if ($urandom_range(0, 29) == 0)
        send_event(CMD_READ, 8'($urandom), 10'($urandom_range(0, k)));
      if ($urandom_range(0, 39) == 0)
        send_event(CMD_TICK, 8'($urandom), 10'($urandom));
    end
    if ($urandom_range(0, 19) != 0) send_event(CMD_BREAK, 8'($urandom), 10'($urandom));
  endtask

  // Mostly well-formed frames, with ticks and reads between them and some
  // fully random events as noise. Idling moods change now and then.
  task automatic run_random(int unsigned count);
    int unsigned stop, pick;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 29) == 0) begin
        pick       = $urandom_range(0, 5);
        src_quiet  = (pick == 0) || (pick == 1);
        sink_quiet = (pick == 0) || (pick == 2);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)
        send_frame();
      else if (pick < 75)
        send_event(CMD_TICK, 8'($urandom), 10'($urandom));
      else if (pick < 83)
        send_event(CMD_READ, 8'($urandom), 10'($urandom_range(0, 512)));
      else if (pick < 85)
        send_event(CMD_READ, 8'($urandom), 10'($urandom_range(513, 1023)));
      else
        send_event(cmd_t'($urandom_range(0, 3)), 8'($urandom), 10'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [WIN_W-1:0] plan [6];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_BYTE;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
    foreach (scene[i]) scene[i] = 8'($urandom);
    plan = '{4'd1, 4'd15, 4'd0, 4'd2, 4'($urandom_range(1, 15)), 4'd7};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset window of 3 ticks.
    send_event(CMD_READ, 8'd0, 10'd0);            // empty store reads zero
    send_event(CMD_TICK, 8'd0, 10'd0);            // window close with no frames
    send_event(CMD_BYTE, 8'd0, 10'd0);            // null start code
    send_event(CMD_BYTE, 8'd255, 10'd1023);
    send_event(CMD_BYTE, 8'h5a, 10'd0);
    send_event(CMD_BREAK, 8'd0, 10'd0);           // good frame, change cleared
    send_event(CMD_READ, 8'd0, 10'd1);
    send_event(CMD_READ, 8'd255, 10'd512);        // last slot
    send_event(CMD_READ, 8'd0, 10'd513);          // out of range
    send_event(CMD_READ, 8'd0, 10'd1023);
    send_event(CMD_BYTE, START_RDM, 10'd0);       // RDM start code
    send_event(CMD_BYTE, 8'd0, 10'd0);
    send_event(CMD_BREAK, 8'd0, 10'd0);
    send_event(CMD_BYTE, 8'haa, 10'd0);           // syntax error start code
    send_event(CMD_BREAK, 8'd0, 10'd0);
    send_event(CMD_BREAK, 8'd0, 10'd0);           // empty frame
    send_event(CMD_BYTE, 8'd0, 10'd0);
    send_event(CMD_BREAK, 8'd0, 10'd0);           // start code only
    send_event(CMD_TICK, 8'd0, 10'd0);
    send_event(CMD_TICK, 8'd0, 10'd0);
    send_event(CMD_TICK, 8'd0, 10'd0);            // closes the window
    send_event(CMD_READ, 8'd0, 10'd2);

    // Random phases, each after a write of the next planned window length.
    foreach (plan[p]) begin
      write_window(plan[p]);
      run_random(RANDOM_ITEMS / 6);
    end

    // Break burst without a tick: frame rate and window counters run high.
    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    repeat (BURST_BREAKS) send_event(CMD_BREAK, 8'($urandom), 10'($urandom));
    send_event(CMD_TICK, 8'd0, 10'd0);
    send_event(CMD_BYTE, 8'd7, 10'd0);
    send_event(CMD_BREAK, 8'd0, 10'd0);
    send_event(CMD_TICK, 8'd0, 10'd0);

    in_tvalid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Run covered %0d events: %0d bytes, %0d breaks, %0d ticks, %0d reads;",
             items_sent, sent_by_cmd[CMD_BYTE], sent_by_cmd[CMD_BREAK],
             sent_by_cmd[CMD_TICK], sent_by_cmd[CMD_READ]);
    $display("%0d result transactions checked over window lengths 3, 0, 1, 2, 7, 15.",
             results_seen);
    if (fails == 0) begin
      $display("** dmx512_frame_monitor: PASSED **");
    end else begin
      $display("** dmx512_frame_monitor: FAILED **");
    end
    $finish;
  end

endmodule
